// ===== src/base64_stream_encoder_top_assert.svh =====
// assertion macros for the base64 stream encoder
// used by the rtl files that check their own logic, no other dependencies
`ifndef BASE64_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE64_STREAM_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define B64E_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// condition must never be seen at a clock edge out of reset
`define B64E_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define B64E_ASSERT(label, clk, rst_n, prop)
`define B64E_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== src/b64e_pkg.sv =====
// shared types, constants and the alphabet function of the base64 stream encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [1:0] PendMax = 2'd2;

  typedef struct packed {
    logic [23:0] bits;
    logic        fin;
  } grp_t;

  function automatic logic [6:0] b64e_char(input logic [5:0] idx);
    logic [6:0] idx7;
    logic [6:0] ch;
    idx7 = {1'b0, idx};
    if (idx < 6'd26) begin
      ch = 7'd65 + idx7;
    end else if (idx < 6'd52) begin
      ch = 7'd97 + (idx7 - 7'd26);
    end else if (idx < 6'd62) begin
      ch = 7'd48 + (idx7 - 7'd52);
    end else if (idx == 6'd62) begin
      ch = 7'd43;
    end else begin
      ch = 7'd47;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== src/b64e_front.sv =====
// front end: accepts bytes and flushes, holds pending bytes, builds 24-bit groups
// depends on b64e_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic               command_i,
  input  wire logic [7:0]         data_byte_i,
  output logic                    full_o,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output b64e_pkg::grp_t          q_data_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] pend0_q, pend1_q;
  logic       accept;
  logic       is_flush;
  logic       emit;

  assign full_o   = q_full_i;
  assign accept   = push_i && !q_full_i;
  assign is_flush = (b64e_pkg::cmd_e'(command_i) == b64e_pkg::CMD_FLUSH);
  assign emit     = accept && (is_flush ? (cnt_q != 2'd0) : (cnt_q == b64e_pkg::PendMax));

  always_comb begin
    if (is_flush) begin
      q_data_o.bits = {pend0_q, (cnt_q == b64e_pkg::PendMax) ? pend1_q : 8'h00, 8'h00};
      q_data_o.fin  = 1'b1;
    end else begin
      q_data_o.bits = {pend0_q, pend1_q, data_byte_i};
      q_data_o.fin  = 1'b0;
    end
  end

  assign q_push_o = emit;

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (is_flush || (cnt_q == b64e_pkg::PendMax)) begin
        cnt_d = 2'd0;
      end else begin
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_flush && (cnt_q == 2'd0)) begin
      pend0_q <= data_byte_i;
    end
    if (accept && !is_flush && (cnt_q == 2'd1)) begin
      pend1_q <= data_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/b64e_fifo.sv =====
// short group queue between the front end and the back end
// depends on b64e_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "base64_stream_encoder_top_assert.svh"

module b64e_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire b64e_pkg::grp_t     data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output b64e_pkg::grp_t          data_o,
  output logic                    empty_o
);

  localparam logic [b64e_pkg::QPtrW-1:0] PtrLast = b64e_pkg::QPtrW'(b64e_pkg::QDepth - 1);
  localparam logic [b64e_pkg::QCntW-1:0] CntFull = b64e_pkg::QCntW'(b64e_pkg::QDepth);

  b64e_pkg::grp_t mem_q [b64e_pkg::QDepth];

  logic [b64e_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [b64e_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [b64e_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                       do_push;
  logic                       do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `B64E_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CntFull)
  `B64E_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o)
  `B64E_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && empty_o)
  `B64E_ASSERT(a_cnt_up, clk_i, rst_ni, (do_push && !do_pop) |=> (cnt_q != '0))
  `B64E_ASSERT(a_ptr_track, clk_i, rst_ni, empty_o |-> (wr_ptr_q == rd_ptr_q))

endmodule

`default_nettype wire

// ===== src/b64e_back.sv =====
// back end: maps each group through the alphabet into the result register
// depends on b64e_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire b64e_pkg::grp_t     q_data_i,
  output logic                    q_pop_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output logic [6:0]              char_0_o,
  output logic [6:0]              char_1_o,
  output logic [6:0]              char_2_o,
  output logic [6:0]              char_3_o,
  output logic                    final_group_o
);

  logic       out_vld_q, out_vld_d;
  logic       load;
  logic [6:0] ch0_q, ch1_q, ch2_q, ch3_q;
  logic       fin_q;

  assign load    = !q_empty_i && (!out_vld_q || pop_i);
  assign q_pop_o = load;

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ch0_q <= b64e_pkg::b64e_char(q_data_i.bits[23:18]);
      ch1_q <= b64e_pkg::b64e_char(q_data_i.bits[17:12]);
      ch2_q <= b64e_pkg::b64e_char(q_data_i.bits[11:6]);
      ch3_q <= b64e_pkg::b64e_char(q_data_i.bits[5:0]);
      fin_q <= q_data_i.fin;
    end
  end

  assign empty_o       = !out_vld_q;
  assign char_0_o      = ch0_q;
  assign char_1_o      = ch1_q;
  assign char_2_o      = ch2_q;
  assign char_3_o      = ch3_q;
  assign final_group_o = fin_q;

endmodule

`default_nettype wire

// ===== src/base64_stream_encoder_top.sv =====
// Base64 stream encoder: one byte or flush command per push, one four-character
// group per result. Bytes are accepted at one per cycle while full is low;
// every third byte, or a flush with one or two bytes held, yields a group that
// goes into the group queue and then into the result register. A flush zero-fills
// the group, writes no '=' padding and sets final_group; a flush with nothing held
// yields nothing. full rises only when the two-entry group queue and the result
// register are all occupied because pop has been held low.
// depends on b64e_pkg, b64e_front, b64e_fifo and b64e_back
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic       command_i,
  input  wire logic [7:0] data_byte_i,
  output logic            empty_o,
  input  wire logic       pop_i,
  output logic [6:0]      char_0_o,
  output logic [6:0]      char_1_o,
  output logic [6:0]      char_2_o,
  output logic [6:0]      char_3_o,
  output logic            final_group_o
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  b64e_pkg::grp_t q_wdata;
  b64e_pkg::grp_t q_rdata;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .full_o      (full_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  b64e_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  b64e_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .char_0_o      (char_0_o),
    .char_1_o      (char_1_o),
    .char_2_o      (char_2_o),
    .char_3_o      (char_3_o),
    .final_group_o (final_group_o)
  );

endmodule

`default_nettype wire

// ===== tb/b64e_group_checker.sv =====
`timescale 1ns / 1ps
// group checker for the base64 stream encoder: watches the byte and group transfers,
// predicts each four-character group and compares it with what the block pops
// depends on b64e_pkg for the command codes
module b64e_group_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic       command_i,
  input  logic [7:0] data_byte_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [6:0] char_0_i,
  input  logic [6:0] char_1_i,
  input  logic [6:0] char_2_i,
  input  logic [6:0] char_3_i,
  input  logic       final_group_i,
  output int         fail_count_o,
  output int         open_groups_o
);

  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [6:0] ch0;
    logic [6:0] ch1;
    logic [6:0] ch2;
    logic [6:0] ch3;
    logic       fin;
  } group_t;

  group_t     expected_groups[$];
  logic [7:0] held_bytes[2];
  logic [1:0] held_count;

  function automatic logic [6:0] alphabet_char(input logic [5:0] idx);
    logic [7:0] ch;
    ch = B64_ALPHABET[8*(63-idx) +: 8];
    return ch[6:0];
  endfunction

  function automatic group_t encode_group(input logic [23:0] grp, input logic fin);
    group_t g;
    g.ch0 = alphabet_char(grp[23:18]);
    g.ch1 = alphabet_char(grp[17:12]);
    g.ch2 = alphabet_char(grp[11:6]);
    g.ch3 = alphabet_char(grp[5:0]);
    g.fin = fin;
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  task automatic predict_byte(input logic cmd, input logic [7:0] b);
    logic [7:0] second;
    if (cmd == b64e_pkg::CMD_FLUSH) begin
      if (held_count != 2'd0) begin
        second = (held_count == 2'd2) ? held_bytes[1] : 8'h00;
        expected_groups.push_back(encode_group({held_bytes[0], second, 8'h00}, 1'b1));
        held_count = 2'd0;
      end
    end else if (held_count == 2'd2) begin
      expected_groups.push_back(encode_group({held_bytes[0], held_bytes[1], b}, 1'b0));
      held_count = 2'd0;
    end else begin
      held_bytes[held_count[0]] = b;
      held_count = held_count + 2'd1;
    end
  endtask

  task automatic check_group();
    group_t want;
    if (expected_groups.size() == 0) begin
      report_mismatch("group with nothing expected",
                      {char_0_i, char_1_i, char_2_i, char_3_i, final_group_i}, 0);
    end else begin
      want = expected_groups.pop_front();
      if (char_0_i !== want.ch0) report_mismatch("char_0", char_0_i, want.ch0);
      if (char_1_i !== want.ch1) report_mismatch("char_1", char_1_i, want.ch1);
      if (char_2_i !== want.ch2) report_mismatch("char_2", char_2_i, want.ch2);
      if (char_3_i !== want.ch3) report_mismatch("char_3", char_3_i, want.ch3);
      if (final_group_i !== want.fin) report_mismatch("final_group", final_group_i, want.fin);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_groups.delete();
      held_count = 2'd0;
      fail_count_o = 0;
      open_groups_o = 0;
    end else begin
      if (push_i && !full_i) predict_byte(command_i, data_byte_i);
      if (pop_i && !empty_i) check_group();
      open_groups_o = expected_groups.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench top for the base64 stream encoder: drives bytes and flushes in bursts,
// pops groups on a stall pattern and gives the verdict
// depends on b64e_pkg, base64_stream_encoder_top and b64e_group_checker
module tb;

  localparam int RandomItems    = 1250;
  localparam int LongStall      = 300;
  localparam int WatchdogLimit  = 3000;
  localparam int TailCycles     = 20;

  logic       clk_i;
  logic       rst_ni;
  logic       push_i;
  logic       full_o;
  logic       command_i;
  logic [7:0] data_byte_i;
  logic       empty_o;
  logic       pop_i;
  logic [6:0] char_0_o;
  logic [6:0] char_1_o;
  logic [6:0] char_2_o;
  logic [6:0] char_3_o;
  logic       final_group_o;

  int fail_count;
  int open_groups;
  int stall_requests;
  int stalls_done;
  int quiet_cycles;
  bit draining;

  base64_stream_encoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .char_0_o     (char_0_o),
    .char_1_o     (char_1_o),
    .char_2_o     (char_2_o),
    .char_3_o     (char_3_o),
    .final_group_o(final_group_o)
  );

  b64e_group_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_i       (full_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .empty_i      (empty_o),
    .pop_i        (pop_i),
    .char_0_i     (char_0_o),
    .char_1_i     (char_1_o),
    .char_2_i     (char_2_o),
    .char_3_i     (char_3_o),
    .final_group_i(final_group_o),
    .fail_count_o (fail_count),
    .open_groups_o(open_groups)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // one byte or flush transfer, held until accepted
  task automatic send_item(input b64e_pkg::cmd_e cmd, input logic [7:0] b);
    @(negedge clk_i);
    push_i      <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= b;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
  endtask

  task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    send_item(b64e_pkg::CMD_DATA, b0);
    send_item(b64e_pkg::CMD_DATA, b1);
    send_item(b64e_pkg::CMD_DATA, b2);
  endtask

  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk_i);
      push_i      <= 1'b0;
      command_i   <= b64e_pkg::cmd_e'($urandom_range(0, 1));
      data_byte_i <= 8'($urandom_range(0, 255));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push_i <= 1'b0;
    while (open_groups != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int sent;
    int burst;
    int gap;
    push_i         = 1'b0;
    pop_i          = 1'b0;
    command_i      = b64e_pkg::CMD_DATA;
    data_byte_i    = 8'h00;
    rst_ni         = 1'b0;
    stall_requests = 0;
    draining       = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // flush with nothing held, data ignored
    send_item(b64e_pkg::CMD_FLUSH, 8'hff);
    send_bytes(8'h00, 8'h00, 8'h00);
    send_bytes(8'hff, 8'hff, 8'hff);
    send_bytes(8'hfb, 8'hef, 8'hbe);
    send_bytes(8'h4d, 8'h61, 8'h6e);
    // one byte then flush
    send_item(b64e_pkg::CMD_DATA, 8'h4d);
    send_item(b64e_pkg::CMD_FLUSH, 8'h5a);
    // two bytes then flush, then a second flush with nothing held
    send_item(b64e_pkg::CMD_DATA, 8'hff);
    send_item(b64e_pkg::CMD_DATA, 8'h80);
    send_item(b64e_pkg::CMD_FLUSH, 8'h00);
    send_item(b64e_pkg::CMD_FLUSH, 8'ha5);
    send_item(b64e_pkg::CMD_DATA, 8'h01);
    send_item(b64e_pkg::CMD_FLUSH, 8'hff);
    wait_drained();

    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 48);
      repeat (burst) begin
        if ($urandom_range(0, 11) == 0) begin
          send_item(b64e_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)));
        end else begin
          send_item(b64e_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
        end
        sent++;
        if (sent == 400) stall_requests++;
        if (sent == 800) wait_drained();
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      idle_sender(gap);
    end
    send_item(b64e_pkg::CMD_FLUSH, 8'h00);

    draining = 1'b1;
    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (fail_count == 0 && open_groups == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int mode;
    int k;
    stalls_done = 0;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      for (k = 0; k < 64; k++) begin
        @(negedge clk_i);
        if (stall_requests != stalls_done) begin
          // long hold-off so the block backs up and raises full
          pop_i <= 1'b0;
          repeat (LongStall) @(negedge clk_i);
          stalls_done++;
        end else if (draining) begin
          pop_i <= 1'b1;
        end else begin
          case (mode)
            0: pop_i <= 1'b1;
            1: pop_i <= 1'($urandom_range(0, 1));
            2: pop_i <= (k % 4 == 0);
            default: pop_i <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

endmodule

// ===== files.f =====
+incdir+src
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_fifo.sv
src/b64e_back.sv
src/base64_stream_encoder_top.sv
tb/b64e_group_checker.sv
tb/tb.sv
